// ----- rtl/s2luv_pkg.sv -----
// Shared constants, types and table builders for the sRGB to CIE L*u*v* core.
// Depends on nothing; s2luv_cbrt, the top level and the testbench import it.
`default_nettype none

package s2luv_pkg;

	localparam int FRAC_W = 30;                 // Q30 fraction bits
	localparam int LIN_W  = 31;                 // Q30 value in [0, 1.0]
	localparam int LH_W   = 14;
	localparam int UC_W   = 16;
	localparam int VC_W   = 15;

	localparam logic [63:0] FIX_ONE  = 64'd1 << FRAC_W;
	localparam logic [63:0] FIX_HALF = 64'd1 << (FRAC_W - 1);

	localparam int DIV_SPS_DEF = 4;             // divider steps per stage

	// Matrix coefficients, scaled by 10000
	localparam logic [13:0] CX_R = 14'd4124;
	localparam logic [13:0] CX_G = 14'd3576;
	localparam logic [13:0] CX_B = 14'd1805;
	localparam logic [13:0] CY_R = 14'd2126;
	localparam logic [13:0] CY_G = 14'd7152;
	localparam logic [13:0] CY_B = 14'd722;
	localparam logic [13:0] CZ_R = 14'd193;
	localparam logic [13:0] CZ_G = 14'd1192;
	localparam logic [13:0] CZ_B = 14'd9505;
	localparam logic [13:0] XYZ_DIV = 14'd10000;
	localparam logic [43:0] XYZ_RND = 44'd5000;

	// L* constants
	localparam logic [30:0] LIN_THR = 31'((64'd8856 << FRAC_W) / 64'd1000000);
	localparam logic [13:0] L_SCALE = 14'd11600;
	localparam int          L_OFF   = 1600;
	localparam logic [19:0] L_LIN   = 20'd903292;
	localparam logic [43:0] L_LIN_RND = 44'(64'd5 << FRAC_W);
	localparam logic [15:0] DIV10_MUL = 16'd52429;
	localparam int          DIV10_SH  = 19;
	localparam int          LH_MAX    = 10000;

	// White point u'n, v'n in Q24
	localparam logic [63:0] WHITE_DEN = 64'd1921696;
	localparam logic [27:0] UN = 28'(((64'd380188 << 24) + WHITE_DEN / 2) / WHITE_DEN);
	localparam logic [27:0] VN = 28'(((64'd900000 << 24) + WHITE_DEN / 2) / WHITE_DEN);

	localparam int U_MIN = -13500;
	localparam int U_MAX = 22500;
	localparam int V_MIN = -14500;
	localparam int V_MAX = 12500;

	typedef logic [LIN_W-1:0] lin_t;
	typedef lin_t lut_t [256];

	function automatic logic [63:0] fix_pow5(input logic [63:0] y);
		logic [63:0] p;
		p = y;
		for (int i = 1; i < 5; i++)
			p = (p * y) >> FRAC_W;
		return p;
	endfunction

	// Linearized channel value in Q30 (gamma 2.4 segment via t^2 * fifth root of t^2)
	function automatic lin_t lin_entry(input int c);
		logic [63:0] cc, t, t2, lo, hi, mid;
		cc = 64'(c);
		if (cc * 64'd100000 <= 64'd1031475)
			return LIN_W'((cc * FIX_ONE * 64'd100 + 64'd164730) / 64'd329460);
		t  = ((64'd1000 * cc + 64'd14025) * FIX_ONE + 64'd134512) / 64'd269025;
		t2 = (t * t + FIX_HALF) >> FRAC_W;
		lo = 64'd0;
		hi = FIX_ONE;
		for (int k = 0; k < 40; k++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (fix_pow5(mid) <= t2)
					lo = mid;
				else
					hi = mid - 64'd1;
			end
		end
		return LIN_W'((t2 * lo + FIX_HALF) >> FRAC_W);
	endfunction

	function automatic lut_t build_lin_lut();
		lut_t tbl;
		for (int c = 0; c < 256; c++)
			tbl[c] = lin_entry(c);
		return tbl;
	endfunction

	localparam lut_t LIN_LUT = build_lin_lut();

	function automatic logic [43:0] mul_coef(input logic [13:0] c, input lin_t l);
		return {30'd0, c} * {13'd0, l};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/s2luv_dly.sv -----
// Delay line of fixed depth that advances on the shared pipeline enable.
// Depends on nothing.
`default_nettype none

module s2luv_dly #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] sh_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				sh_q[i] <= '0;
		end else if (en) begin
			sh_q[0] <= din;
			for (int i = 1; i < DEPTH; i++)
				sh_q[i] <= sh_q[i-1];
		end
	end

	assign dout = sh_q[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/s2luv_div.sv -----
// Pipelined restoring divider, SPS quotient bits per stage.
// Depends on nothing; caller guarantees num >> QW < den.
`default_nettype none

module s2luv_div #(
	parameter int NW  = 44,
	parameter int DW  = 14,
	parameter int QW  = 31,
	parameter int SPS = 4
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);

	localparam int NST = (QW + SPS - 1) / SPS;

	logic [DW-1:0] rem_s [NST];
	logic [QW-1:0] nq_s  [NST];
	logic [DW-1:0] den_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		localparam int NSTEP = (QW - k * SPS < SPS) ? (QW - k * SPS) : SPS;
		logic [DW-1:0] r_in, r_out, d_in;
		logic [QW-1:0] q_in, q_out;
		logic [DW:0]   t;

		if (k == 0) begin : g_first
			assign r_in = DW'(num[NW-1:QW]);
			assign q_in = num[QW-1:0];
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign q_in = nq_s[k-1];
			assign d_in = den_s[k-1];
		end

		// shift in one numerator bit, subtract when it fits
		always_comb begin
			r_out = r_in;
			q_out = q_in;
			t     = '0;
			for (int i = 0; i < NSTEP; i++) begin
				t = {r_out, q_out[QW-1]};
				if (t >= {1'b0, d_in}) begin
					t     = t - {1'b0, d_in};
					q_out = {q_out[QW-2:0], 1'b1};
				end else begin
					q_out = {q_out[QW-2:0], 1'b0};
				end
				r_out = t[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_out;
				nq_s[k]  <= q_out;
				den_s[k] <= d_in;
			end
		end
	end

	assign quo = nq_s[NST-1];

endmodule

`default_nettype wire

// ----- rtl/s2luv_cbrt.sv -----
// Pipelined Q30 integer cube root, one result bit per two stages.
// Depends on s2luv_pkg.
`default_nettype none

module s2luv_cbrt
	import s2luv_pkg::*;
(
	input  wire logic clk,
	input  wire logic en,
	input  wire lin_t y,
	output lin_t      root,
	output lin_t      y_out
);

	lin_t             ca_s [LIN_W];
	lin_t             cp_s [LIN_W];
	logic [31:0]      sq_s [LIN_W];
	lin_t             ya_s [LIN_W];
	lin_t             c_s  [LIN_W];
	lin_t             yb_s [LIN_W];

	for (genvar j = 0; j < LIN_W; j++) begin : g_bit
		lin_t        c_prev, y_in, cand;
		logic [61:0] p2;
		logic [62:0] p3;
		logic [32:0] cube;

		if (j == 0) begin : g_first
			assign c_prev = '0;
			assign y_in   = y;
		end else begin : g_next
			assign c_prev = c_s[j-1];
			assign y_in   = yb_s[j-1];
		end

		// try the next bit: square first
		assign cand = c_prev | (lin_t'(1) << (LIN_W - 1 - j));
		assign p2   = 62'(cand) * 62'(cand);

		always_ff @(posedge clk) begin
			if (en) begin
				ca_s[j] <= cand;
				cp_s[j] <= c_prev;
				sq_s[j] <= p2[61:30];
				ya_s[j] <= y_in;
			end
		end

		// then cube, keep the bit when the cube stays at or below y
		assign p3   = 63'(sq_s[j]) * 63'(ca_s[j]);
		assign cube = p3[62:30];

		always_ff @(posedge clk) begin
			if (en) begin
				c_s[j]  <= (cube <= 33'(ya_s[j])) ? ca_s[j] : cp_s[j];
				yb_s[j] <= ya_s[j];
			end
		end
	end

	assign root  = c_s[LIN_W-1];
	assign y_out = yb_s[LIN_W-1];

endmodule

`default_nettype wire

// ----- rtl/srgb_to_cie_luv_pixel_core.sv -----
// Top level: 8-bit sRGB pixel to CIE L*u*v* (D65) in hundredths, fully pipelined.
// Depends on s2luv_pkg, s2luv_dly, s2luv_div, s2luv_cbrt.
//
//  channel | signals                              | direction
//  pixel   | pixel_valid, pixel_ready, red/green/blue | into the core
//  luv     | luv_valid, luv_ready, lightness, u_chroma, v_chroma | out of the core
//
// One pixel enters per clock unless the output stalls; stages in order: table, matrix,
// divide by 10000, denominator, cube root (two stages per result bit), L* and chroma.
// The u'/v' dividers run beside the cube root and add nothing to the latency.
// All stages advance together on one enable; pixel_ready is high whenever the output
// register is empty or being taken, so bubbles fill while a result waits only if
// luv_ready is high. Reset clears valid, u'/v' and black delays; others hold garbage.
`default_nettype none

module srgb_to_cie_luv_pixel_core
	import s2luv_pkg::*;
#(
	parameter int DIV_SPS = DIV_SPS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pixel_valid,
	output logic                        pixel_ready,
	input  wire logic [7:0]             red,
	input  wire logic [7:0]             green,
	input  wire logic [7:0]             blue,
	output logic                        luv_valid,
	input  wire logic                   luv_ready,
	output logic      [LH_W-1:0]        lightness,
	output logic signed [UC_W-1:0]      u_chroma,
	output logic signed [VC_W-1:0]      v_chroma
);

	localparam int QU       = 27;
	localparam int QV       = 25;
	localparam int LXYZ     = 3;
	localparam int LU       = (QU + DIV_SPS - 1) / DIV_SPS;
	localparam int LV       = (QV + DIV_SPS - 1) / DIV_SPS;
	localparam int CBRT_LAT = 2 * LIN_W;
	localparam int LAT      = 2 + LXYZ + 1 + CBRT_LAT + 4;

	// Divide by 10000 as divide by 16 then by 625, each 625 step by reciprocal
	localparam logic [19:0] DIV625    = 20'd625;
	localparam logic [20:0] DIV625_M1 = 21'd1717987;       // ceil(2^30 / 625)
	localparam logic [30:0] DIV625_M2 = 31'd1759218605;    // ceil(2^40 / 625)

	localparam logic signed [22:0] UMIN23 = 23'(U_MIN);
	localparam logic signed [22:0] UMAX23 = 23'(U_MAX);
	localparam logic signed [22:0] VMIN23 = 23'(V_MIN);
	localparam logic signed [22:0] VMAX23 = 23'(V_MAX);

	// Whole pipeline advances when the output register is free or being taken
	logic adv;
	assign adv         = !luv_valid || luv_ready;
	assign pixel_ready = adv;

	s2luv_dly #(.W(1), .DEPTH(LAT)) u_vld (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(pixel_valid), .dout(luv_valid)
	);

	// Stage 1: linearize each channel through the constant table
	lin_t rl_s1, gl_s1, bl_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			rl_s1 <= LIN_LUT[red];
			gl_s1 <= LIN_LUT[green];
			bl_s1 <= LIN_LUT[blue];
		end
	end

	// Stage 2: matrix rows, scaled by 10000, with the rounding bias
	logic [43:0] sx_s2, sy_s2, sz_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s2 <= mul_coef(CX_R, rl_s1) + mul_coef(CX_G, gl_s1)
				+ mul_coef(CX_B, bl_s1) + XYZ_RND;
			sy_s2 <= mul_coef(CY_R, rl_s1) + mul_coef(CY_G, gl_s1)
				+ mul_coef(CY_B, bl_s1) + XYZ_RND;
			sz_s2 <= mul_coef(CZ_R, rl_s1) + mul_coef(CZ_G, gl_s1)
				+ mul_coef(CZ_B, bl_s1) + XYZ_RND;
		end
	end

	// Divide by 10000 to get X, Y, Z in Q30. Drop the low 4 bits (divide by 16),
	// split the rest into high and low 20 bits, divide the high part by 625,
	// fold its remainder into the low part and divide that by 625 too.
	logic [43:0] xyz_sum [3];
	lin_t        xyz_q   [3];
	lin_t        x_d, y_d, z_d;

	assign xyz_sum[0] = sx_s2;
	assign xyz_sum[1] = sy_s2;
	assign xyz_sum[2] = sz_s2;

	for (genvar ch = 0; ch < 3; ch++) begin : g_xyz
		logic [39:0] m16;
		logic [40:0] ph;
		logic [9:0]  rh;
		logic [59:0] pr;
		logic [10:0] qh_s2a, qh_s2b;
		logic [19:0] hi_s2a, lo_s2a;
		logic [29:0] rem_s2b;
		lin_t        q_s2c;

		assign m16 = xyz_sum[ch][43:4];
		assign ph  = 41'(m16[39:20]) * 41'(DIV625_M1);
		assign rh  = 10'(hi_s2a - 20'(qh_s2a) * DIV625);
		assign pr  = 60'(rem_s2b) * 60'(DIV625_M2);

		always_ff @(posedge clk) begin
			if (adv) begin
				qh_s2a  <= ph[40:30];
				hi_s2a  <= m16[39:20];
				lo_s2a  <= m16[19:0];
				qh_s2b  <= qh_s2a;
				rem_s2b <= {rh, lo_s2a};
				q_s2c   <= {qh_s2b, pr[59:40]};
			end
		end

		assign xyz_q[ch] = q_s2c;
	end

	assign x_d = xyz_q[0];
	assign y_d = xyz_q[1];
	assign z_d = xyz_q[2];

	// Stage 3: denominator d = X + 15Y + 3Z
	lin_t        x_s3, y_s3;
	logic [34:0] d_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3 <= x_d;
			y_s3 <= y_d;
			d_s3 <= 35'(x_d) + (35'(y_d) << 4) - 35'(y_d) + (35'(z_d) << 1) + 35'(z_d);
		end
	end

	// u' = 4X * 2^24 / d, v' = 9Y * 2^24 / d
	logic [56:0] num_u;
	logic [58:0] num_v;
	logic [QU-1:0] up_d, up_dl;
	logic [QV-1:0] vp_d, vp_dl;
	logic          zero_dl;

	assign num_u = {x_s3, 26'd0};
	assign num_v = {(35'(y_s3) << 3) + 35'(y_s3), 24'd0};

	s2luv_div #(.NW(57), .DW(35), .QW(QU), .SPS(DIV_SPS)) u_div_u (
		.clk(clk), .en(adv), .num(num_u), .den(d_s3), .quo(up_d)
	);
	s2luv_div #(.NW(59), .DW(35), .QW(QV), .SPS(DIV_SPS)) u_div_v (
		.clk(clk), .en(adv), .num(num_v), .den(d_s3), .quo(vp_d)
	);

	// Hold u', v' and the black flag until L* catches up
	s2luv_dly #(.W(QU), .DEPTH(CBRT_LAT + 2 - LU)) u_dly_u (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(up_d), .dout(up_dl)
	);
	s2luv_dly #(.W(QV), .DEPTH(CBRT_LAT + 2 - LV)) u_dly_v (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(vp_d), .dout(vp_dl)
	);
	s2luv_dly #(.W(1), .DEPTH(CBRT_LAT + 2)) u_dly_z (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(d_s3 == '0), .dout(zero_dl)
	);

	// Cube root of Y for the upper L* segment
	lin_t cr_c, y_c;

	s2luv_cbrt u_cbrt (
		.clk(clk), .en(adv), .y(y_s3), .root(cr_c), .y_out(y_c)
	);

	// Stage 4: scale both L* segments
	logic [44:0] pc_s4;
	logic [43:0] pl_s4;
	logic        br_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s4 <= 45'(L_SCALE) * 45'(cr_c);
			pl_s4 <= 44'(L_LIN) * 44'(y_c[23:0]) + L_LIN_RND;
			br_s4 <= y_c > LIN_THR;
		end
	end

	// Stage 5: round, pick the segment, clamp L*
	logic [44:0]        pc_rnd;
	logic signed [15:0] lhc;
	logic [13:0]        w10;
	logic [31:0]        q10_p;
	logic [LH_W-1:0]    lh_next, lh_s5;

	always_comb begin
		pc_rnd  = pc_s4 + 45'(FIX_HALF);
		lhc     = $signed({1'b0, pc_rnd[44:30]}) - 16'(L_OFF);
		w10     = pl_s4[43:30];
		q10_p   = 32'(w10) * 32'(DIV10_MUL);
		if (br_s4) begin
			if (lhc < 0)
				lh_next = '0;
			else if (lhc > 16'(LH_MAX))
				lh_next = LH_W'(LH_MAX);
			else
				lh_next = LH_W'(lhc);
		end else begin
			if (LH_W'(q10_p[31:DIV10_SH]) > LH_W'(LH_MAX))
				lh_next = LH_W'(LH_MAX);
			else
				lh_next = LH_W'(q10_p[31:DIV10_SH]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			lh_s5 <= lh_next;
	end

	// Stage 6: 13 * L* * (u' - u'n), same for v
	logic [17:0]        lh13;
	logic signed [27:0] du, dv;
	logic signed [46:0] pu_s6, pv_s6;
	logic               zero_s6;
	logic [LH_W-1:0]    lh_s6;

	assign lh13 = (18'(lh_s5) << 3) + (18'(lh_s5) << 2) + 18'(lh_s5);
	assign du   = $signed({1'b0, up_dl}) - $signed(UN);
	assign dv   = $signed(28'(vp_dl)) - $signed(VN);

	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s6   <= 47'($signed({1'b0, lh13})) * 47'(du);
			pv_s6   <= 47'($signed({1'b0, lh13})) * 47'(dv);
			zero_s6 <= zero_dl;
			lh_s6   <= lh_s5;
		end
	end

	// Stage 7: divide by 2^24 rounding half away from zero, clamp, output register
	logic signed [46:0] mag_u, mag_v;
	logic signed [22:0] uh, vh;
	logic signed [UC_W-1:0] u_next;
	logic signed [VC_W-1:0] v_next;
	logic [LH_W-1:0]        lh_s7;
	logic signed [UC_W-1:0] u_s7;
	logic signed [VC_W-1:0] v_s7;

	always_comb begin
		mag_u = (pu_s6 < 0) ? -pu_s6 : pu_s6;
		mag_v = (pv_s6 < 0) ? -pv_s6 : pv_s6;
		uh    = 23'((mag_u + 47'sd8388608) >>> 24);
		vh    = 23'((mag_v + 47'sd8388608) >>> 24);
		if (pu_s6 < 0)
			uh = -uh;
		if (pv_s6 < 0)
			vh = -vh;
		if (uh < UMIN23)
			uh = UMIN23;
		else if (uh > UMAX23)
			uh = UMAX23;
		if (vh < VMIN23)
			vh = VMIN23;
		else if (vh > VMAX23)
			vh = VMAX23;
		// black pixel: no chromaticity
		u_next = zero_s6 ? '0 : UC_W'(uh);
		v_next = zero_s6 ? '0 : VC_W'(vh);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lh_s7 <= lh_s6;
			u_s7  <= u_next;
			v_s7  <= v_next;
		end
	end

	assign lightness = lh_s7;
	assign u_chroma  = u_s7;
	assign v_chroma  = v_s7;

	a_lh_range: assert property (@(posedge clk) disable iff (!arst_n)
		luv_valid |-> lightness <= LH_W'(LH_MAX))
		else $error("lightness above 100.00");

	a_dark_no_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		(luv_valid && lightness == '0) |-> (u_chroma == '0 && v_chroma == '0))
		else $error("chroma nonzero at zero lightness");

	a_chroma_range: assert property (@(posedge clk) disable iff (!arst_n)
		luv_valid |-> ($signed(u_chroma) >= $signed(UC_W'(U_MIN))
			&& $signed(u_chroma) <= $signed(UC_W'(U_MAX))
			&& $signed(v_chroma) >= $signed(VC_W'(V_MIN))
			&& $signed(v_chroma) <= $signed(VC_W'(V_MAX))))
		else $error("chroma out of range");

endmodule

`default_nettype wire

// ----- test/tb_srgb_to_cie_luv_pixel_core.sv -----
// Self-checking testbench for srgb_to_cie_luv_pixel_core: drives 8-bit sRGB pixels,
// predicts L*u*v* in hundredths with its own integer model and checks every transfer.
// Depends on s2luv_pkg (widths) and the core RTL.
`default_nettype none

module tb_srgb_to_cie_luv_pixel_core;
	import s2luv_pkg::*;

	localparam int PERIOD_HALF = 10;
	localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest legal run
	localparam int DRAIN_WAIT  = 120;     // pipeline is 72 deep
	localparam int RANDOM_ITEMS = 680;
	localparam longint unsigned Q_ONE  = 64'd1 << 30;
	localparam longint unsigned Q_HALF = 64'd1 << 29;

	typedef struct packed {
		logic [LH_W-1:0]        l;
		logic signed [UC_W-1:0] u;
		logic signed [VC_W-1:0] v;
	} luv_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	logic [7:0] red = '0, green = '0, blue = '0;
	logic luv_valid;
	logic luv_ready = 1'b0;
	logic [LH_W-1:0] lightness;
	logic signed [UC_W-1:0] u_chroma;
	logic signed [VC_W-1:0] v_chroma;

	luv_t pending_luv[$];
	longint unsigned gamma_rom [256];
	int mismatches = 0;
	int cycles = 0;
	bit steady = 1'b0;  // suppress idling on both sides

	srgb_to_cie_luv_pixel_core dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
		.red(red), .green(green), .blue(blue),
		.luv_valid(luv_valid), .luv_ready(luv_ready),
		.lightness(lightness), .u_chroma(u_chroma), .v_chroma(v_chroma)
	);

	always begin
		#PERIOD_HALF clk = 1'b1;
		#PERIOD_HALF clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	// Q30 power with every product floored back to Q30.
	function automatic longint unsigned qpow(input longint unsigned y, input int n);
		longint unsigned p;
		p = y;
		for (int i = 1; i < n; i++)
			p = (p * y) >> 30;
		return p;
	endfunction

	// Largest Q30 value in [0, 1.0] whose n-th power does not exceed r.
	function automatic longint unsigned qroot(input longint unsigned r, input int n);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = Q_ONE;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (qpow(mid, n) <= r)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// sRGB code to linear light, Q30: linear toe, else t^2 * fifth root of t^2.
	function automatic longint unsigned gamma_expand(input int c);
		longint unsigned cc, t, t2;
		cc = longint'(c);
		if (cc * 100000 <= 1031475)
			return (cc * Q_ONE * 100 + 164730) / 329460;
		t  = ((1000 * cc + 14025) * Q_ONE + 134512) / 269025;
		t2 = (t * t + Q_HALF) >> 30;
		return (t2 * qroot(t2, 5) + Q_HALF) >> 30;
	endfunction

	// Divide with rounding half away from zero.
	function automatic longint div_away(input longint num, input longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic luv_t pixel_to_luv(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		longint unsigned rl, gl, bl, x, y, z, d, wu, wv;
		longint lh, uh, vh, up, vp;
		luv_t res;
		rl = gamma_rom[r];
		gl = gamma_rom[g];
		bl = gamma_rom[b];
		x = (4124 * rl + 3576 * gl + 1805 * bl + 5000) / 10000;
		y = (2126 * rl + 7152 * gl + 722 * bl + 5000) / 10000;
		z = (193 * rl + 1192 * gl + 9505 * bl + 5000) / 10000;
		d = x + 15 * y + 3 * z;
		uh = 0;
		vh = 0;
		// cube root above the 0.008856 knee, 7.787 slope below it
		if (y * 1000000 > 8856 * Q_ONE)
			lh = longint'((11600 * qroot(y, 3) + Q_HALF) >> 30) - 1600;
		else
			lh = longint'((903292 * y / 10 + Q_HALF) >> 30);
		lh = clip(lh, 0, 10000);
		// black leaves d at zero: chroma stays zero instead of dividing
		if (d != 0) begin
			wu = ((64'd380188 << 24) + 64'd1921696 / 2) / 64'd1921696;
			wv = ((64'd900000 << 24) + 64'd1921696 / 2) / 64'd1921696;
			up = longint'(((4 * x) << 24) / d);
			vp = longint'(((9 * y) << 24) / d);
			uh = clip(div_away(13 * lh * (up - longint'(wu)), 64'sd1 << 24), -13500, 22500);
			vh = clip(div_away(13 * lh * (vp - longint'(wv)), 64'sd1 << 24), -14500, 12500);
		end
		res.l = lh[LH_W-1:0];
		res.u = uh[UC_W-1:0];
		res.v = vh[VC_W-1:0];
		return res;
	endfunction

	// ---------------------------------------------------------------- idling

	// Mostly back to back, sometimes a few cycles, rarely a long gap.
	function automatic int pick_gap();
		int dice;
		if (steady)
			return 0;
		dice = $urandom_range(99);
		if (dice < 60)
			return 0;
		if (dice < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	// Send one pixel; return at the edge of its transfer, with the expectation queued.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do
			@(posedge clk);
		while (!pixel_ready);
		pending_luv.insert(pending_luv.size(), pixel_to_luv(r, g, b));
	endtask

	// Hold the sender until every queued result has been taken.
	task automatic wait_drained();
		pixel_valid <= 1'b0;
		while (pending_luv.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	// Take results at each transfer and compare against the oldest expectation;
	// drive the next ready value with random stalls of varied length.
	int stall_left = 0;
	int burst_left = 0;
	always @(posedge clk) begin
		luv_t want;
		cycles <= cycles + 1;
		if (arst_n && luv_valid && luv_ready) begin
			if (pending_luv.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result L=%0d u=%0d v=%0d", lightness, u_chroma,
						v_chroma);
			end else begin
				want = pending_luv.pop_front();
				if (want.l !== lightness || want.u !== u_chroma || want.v !== v_chroma) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected L=%0d u=%0d v=%0d, got L=%0d u=%0d v=%0d",
							want.l, want.u, want.v, lightness, u_chroma, v_chroma);
				end
			end
		end
		if (!arst_n || steady) begin
			luv_ready <= arst_n;
		end else if (stall_left > 0) begin
			stall_left--;
			luv_ready <= 1'b0;
		end else if (burst_left > 0) begin
			burst_left--;
			luv_ready <= 1'b1;
		end else begin
			burst_left = $urandom_range(12);
			stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 5)
				: $urandom_range(3);
			luv_ready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("[srgb_to_cie_luv_pixel_core] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Extremes, primaries, the toe/gamma knee, black and white.
	task automatic test_corners();
		send_pixel(8'd0, 8'd0, 8'd0);        // black: chroma forced to zero
		send_pixel(8'd255, 8'd255, 8'd255);  // reference white
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd10, 8'd10, 8'd10);     // last code on the linear toe
		send_pixel(8'd11, 8'd11, 8'd11);     // first code on the gamma curve
		send_pixel(8'd1, 8'd0, 8'd0);        // darkest nonblack, linear L* segment
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd20, 8'd20, 8'd20);     // near the L* knee
		send_pixel(8'd21, 8'd22, 8'd23);
		send_pixel(8'h55, 8'hAA, 8'h55);
		send_pixel(8'hAA, 8'h55, 8'hAA);
		send_pixel(8'h80, 8'h7F, 8'h01);
		send_pixel(8'hFE, 8'h01, 8'hFE);
	endtask

	// Random pixels, with dark and gray pixels mixed in.
	task automatic test_random_pixels(input int count);
		logic [7:0] r, g, b;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: begin
					r = 8'($urandom_range(30));
					g = 8'($urandom_range(30));
					b = 8'($urandom_range(30));
				end
				1: begin
					r = 8'($urandom_range(255));
					g = r;
					b = r;
				end
				default: begin
					r = 8'($urandom_range(255));
					g = 8'($urandom_range(255));
					b = 8'($urandom_range(255));
				end
			endcase
			send_pixel(r, g, b);
		end
	endtask

	// Full-rate stretch: no gaps on either side.
	task automatic test_full_rate();
		steady = 1'b1;
		test_random_pixels(100);
		steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int c = 0; c < 256; c++)
			gamma_rom[c] = gamma_expand(c);
		test_corners();
		wait_drained();
		test_random_pixels(RANDOM_ITEMS / 2);
		wait_drained();
		test_full_rate();
		test_random_pixels(RANDOM_ITEMS / 2);
		wait_drained();
		if (mismatches == 0 && pending_luv.size() == 0)
			$display("[srgb_to_cie_luv_pixel_core] OK");
		else
			$display("[srgb_to_cie_luv_pixel_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
